// ===== hdl/fbfl_pkg.sv =====
// shared types and constants of the fixed block free list allocator
`timescale 1ns / 1ps

package fbfl_pkg;

  // pool geometry
  localparam int unsigned MAX_BLOCKS = 256;
  localparam int unsigned IDX_W      = $clog2(MAX_BLOCKS);
  localparam int unsigned CNT_W      = IDX_W + 1;

  // configuration register widths and reset values
  localparam int unsigned CFG_W       = 32;
  localparam int unsigned CFG_ADDR_W  = 2;
  localparam int unsigned BASE_W      = 32;
  localparam int unsigned SIZE_W      = 16;
  localparam int unsigned COUNT_W     = 9;
  localparam int unsigned PROD_W      = IDX_W + SIZE_W;

  localparam logic [BASE_W-1:0]  BASE_RST  = '0;
  localparam logic [SIZE_W-1:0]  SIZE_RST  = SIZE_W'(64);
  localparam logic [COUNT_W-1:0] COUNT_RST = COUNT_W'(256);

  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_BASE  = 2'd0,
    REG_SIZE  = 2'd1,
    REG_COUNT = 2'd2
  } reg_idx_e;

  typedef enum logic [1:0] {
    CMD_INIT  = 2'd0,
    CMD_ALLOC = 2'd1,
    CMD_FREE  = 2'd2
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_EMPTY     = 2'd1,
    ST_ZERO_INIT = 2'd2,
    ST_BAD_INDEX = 2'd3
  } status_e;

  // request beat
  typedef struct packed {
    logic [1:0]       cmd;
    logic [IDX_W-1:0] block_index;
  } req_t;

  // result beat
  typedef struct packed {
    logic [1:0]        status;
    logic [IDX_W-1:0]  alloc_index;
    logic [BASE_W-1:0] alloc_address;
    logic [CNT_W-1:0]  free_blocks;
  } rsp_t;

  // controller to datapath
  typedef struct packed {
    logic    init_start;
    logic    init_step;
    logic    alloc_read;
    logic    alloc_pop;
    logic    free_push;
    logic    res_load;
    status_e res_status;
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic count_zero;
    logic pool_empty;
    logic bad_index;
    logic pool_full;
    logic init_last;
  } dp_sts_t;

endpackage

// ===== hdl/fbfl_ctrl.sv =====
// sequencing state machine of the free list allocator
`timescale 1ns / 1ps

module fbfl_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start,
  input  logic [1:0]       cmd_i,
  input  fbfl_pkg::dp_sts_t sts_i,
  output fbfl_pkg::dp_cmd_t ctl_o,
  output logic             busy
);
  import fbfl_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE  = 3'b001,
    S_ALLOC = 3'b010,
    S_INIT  = 3'b100
  } state_e;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    ctl_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        if (start) begin
          unique case (cmd_e'(cmd_i))
            CMD_INIT: begin
              if (sts_i.count_zero) begin
                ctl_o.res_load   = 1'b1;
                ctl_o.res_status = ST_ZERO_INIT;
              end else begin
                ctl_o.init_start = 1'b1;
                state_d          = S_INIT;
              end
            end
            CMD_ALLOC: begin
              if (sts_i.pool_empty) begin
                ctl_o.res_load   = 1'b1;
                ctl_o.res_status = ST_EMPTY;
              end else begin
                ctl_o.alloc_read = 1'b1;
                state_d          = S_ALLOC;
              end
            end
            CMD_FREE: begin
              ctl_o.res_load = 1'b1;
              if (sts_i.bad_index) begin
                ctl_o.res_status = ST_BAD_INDEX;
              end else begin
                ctl_o.res_status = ST_OK;
                ctl_o.free_push  = !sts_i.pool_full;
              end
            end
            default: begin
              ctl_o.res_load   = 1'b1;
              ctl_o.res_status = ST_OK;
            end
          endcase
        end
      end
      S_ALLOC: begin
        ctl_o.alloc_pop  = 1'b1;
        ctl_o.res_load   = 1'b1;
        ctl_o.res_status = ST_OK;
        state_d          = S_IDLE;
      end
      S_INIT: begin
        ctl_o.init_step = 1'b1;
        if (sts_i.init_last) begin
          ctl_o.res_load   = 1'b1;
          ctl_o.res_status = ST_OK;
          state_d          = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign busy = (state_q != S_IDLE);

endmodule

// ===== hdl/fbfl_datapath.sv =====
// link memory, list registers, config registers and result register
`timescale 1ns / 1ps

module fbfl_datapath (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [fbfl_pkg::CFG_ADDR_W-1:0]  cfg_addr_i,
  input  logic [fbfl_pkg::CFG_W-1:0]       cfg_wdata_i,
  input  logic [fbfl_pkg::IDX_W-1:0]       block_index_i,
  input  fbfl_pkg::dp_cmd_t                ctl_i,
  output fbfl_pkg::dp_sts_t                sts_o,
  output logic                             done_o,
  output fbfl_pkg::rsp_t                   rsp_o
);
  import fbfl_pkg::*;

  logic [BASE_W-1:0]  base_q;
  logic [SIZE_W-1:0]  size_q;
  logic [COUNT_W-1:0] count_q;

  logic [IDX_W-1:0] head_q, head_d;
  logic [CNT_W-1:0] free_q, free_d;
  logic [CNT_W-1:0] total_q, total_d;

  logic [IDX_W-1:0]  ctr_q;
  logic [IDX_W-1:0]  last_q;
  logic [IDX_W-1:0]  rd_q;
  logic [PROD_W-1:0] prod_q;

  logic [IDX_W-1:0] link_mem [MAX_BLOCKS];
  logic             mem_we;
  logic [IDX_W-1:0] mem_waddr;
  logic [IDX_W-1:0] mem_wdata;

  logic [COUNT_W-1:0] n_clip;
  logic [CNT_W-1:0]   n_init;

  rsp_t rsp_q;
  logic done_q;

  // config registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q  <= BASE_RST;
      size_q  <= SIZE_RST;
      count_q <= COUNT_RST;
    end else if (cfg_we_i) begin
      unique case (reg_idx_e'(cfg_addr_i))
        REG_BASE:  base_q  <= cfg_wdata_i[BASE_W-1:0];
        REG_SIZE:  size_q  <= cfg_wdata_i[SIZE_W-1:0];
        REG_COUNT: count_q <= cfg_wdata_i[COUNT_W-1:0];
        default: ;
      endcase
    end
  end

  // count clipped to pool depth
  assign n_clip = (count_q > COUNT_W'(MAX_BLOCKS)) ? COUNT_W'(MAX_BLOCKS) : count_q;
  assign n_init = {1'b0, last_q} + CNT_W'(1);

  // link memory write port: init sweep or free push
  always_comb begin
    mem_we    = ctl_i.init_step || ctl_i.free_push;
    mem_waddr = ctl_i.init_step ? ctr_q : block_index_i;
    if (ctl_i.init_step) begin
      mem_wdata = (ctr_q == last_q) ? '0 : ctr_q + IDX_W'(1);
    end else begin
      mem_wdata = head_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      link_mem[mem_waddr] <= mem_wdata;
    end
    if (ctl_i.alloc_read) begin
      rd_q   <= link_mem[head_q];
      prod_q <= PROD_W'(head_q) * PROD_W'(size_q);
    end
  end

  // init sweep counter
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctr_q  <= '0;
      last_q <= '0;
    end else if (ctl_i.init_start) begin
      ctr_q  <= '0;
      last_q <= IDX_W'(n_clip - COUNT_W'(1));
    end else if (ctl_i.init_step) begin
      ctr_q <= ctr_q + IDX_W'(1);
    end
  end

  // list head and counts
  always_comb begin
    head_d  = head_q;
    free_d  = free_q;
    total_d = total_q;
    if (ctl_i.init_step && (ctr_q == last_q)) begin
      head_d  = '0;
      free_d  = n_init;
      total_d = n_init;
    end
    if (ctl_i.alloc_pop) begin
      head_d = rd_q;
      free_d = free_q - CNT_W'(1);
    end
    if (ctl_i.free_push) begin
      head_d = block_index_i;
      free_d = free_q + CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q  <= '0;
      free_q  <= '0;
      total_q <= '0;
    end else begin
      head_q  <= head_d;
      free_q  <= free_d;
      total_q <= total_d;
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= ctl_i.res_load;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.res_load) begin
      rsp_q.status      <= ctl_i.res_status;
      rsp_q.free_blocks <= free_d;
      if (ctl_i.alloc_pop) begin
        rsp_q.alloc_index   <= head_q;
        rsp_q.alloc_address <= base_q + BASE_W'(prod_q);
      end else begin
        rsp_q.alloc_index   <= '0;
        rsp_q.alloc_address <= '0;
      end
    end
  end

  assign done_o = done_q;
  assign rsp_o  = rsp_q;

  assign sts_o.count_zero = (count_q == '0);
  assign sts_o.pool_empty = (free_q == '0);
  assign sts_o.bad_index  = ({1'b0, block_index_i} >= total_q);
  assign sts_o.pool_full  = (free_q >= total_q);
  assign sts_o.init_last  = (ctr_q == last_q);

  a_count_le_total: assert property (@(posedge clk_i) disable iff (!rst_ni)
    free_q <= total_q)
    else $error("free count above total");

  a_pop_after_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl_i.alloc_pop |-> $past(ctl_i.alloc_read))
    else $error("pop without link read");

  a_write_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(ctl_i.init_step && (ctl_i.free_push || ctl_i.alloc_read)))
    else $error("init sweep overlaps list access");

  a_done_after_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl_i.res_load |=> done_q)
    else $error("result load without strobe");

endmodule

// ===== hdl/fixed_block_free_list_allocator.sv =====
// top level of the fixed block free list allocator
// free, bad index, empty alloc and zero-count init give the result in the cycle after accept
// a successful alloc goes through the registered link memory read in S_ALLOC before its result is registered
// init with n blocks does one link memory write per cycle
// busy stays high while an alloc or init is under way; done is a one-cycle strobe, no stall
// reset clears head, counts and control; link memory contents are undefined until init
`timescale 1ns / 1ps

module fixed_block_free_list_allocator (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // configuration write port
  input  logic                            cfg_we_i,
  input  logic [fbfl_pkg::CFG_ADDR_W-1:0] cfg_addr_i,
  input  logic [fbfl_pkg::CFG_W-1:0]      cfg_wdata_i,
  // command beat
  input  logic                            start,
  input  fbfl_pkg::req_t                  req_i,
  output logic                            busy,
  // result beat
  output logic                            done_o,
  output fbfl_pkg::rsp_t                  rsp_o
);
  import fbfl_pkg::*;

  dp_cmd_t ctl;   // controller commands
  dp_sts_t sts;   // datapath status flags

  // state machine: decides each command from the status flags
  fbfl_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .cmd_i  (req_i.cmd),
    .sts_i  (sts),
    .ctl_o  (ctl),
    .busy   (busy)
  );

  // link memory, head, counts, config and result registers
  fbfl_datapath u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_addr_i    (cfg_addr_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .block_index_i (req_i.block_index),
    .ctl_i         (ctl),
    .sts_o         (sts),
    .done_o        (done_o),
    .rsp_o         (rsp_o)
  );

endmodule

// ===== tb/sv/fixed_block_free_list_allocator_tb.sv =====
// self-checking testbench of the fixed block free list allocator
`timescale 1ns / 1ps

module fixed_block_free_list_allocator_tb;
  import fbfl_pkg::*;

  // command code the block leaves unused, must behave as a no-op
  localparam logic [1:0] CMD_UNUSED = 2'd3;
  localparam int unsigned PHASES      = 8;
  localparam int unsigned PHASE_ITEMS = 100;
  localparam int unsigned MAX_ERR_LOG = 10;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [CFG_ADDR_W-1:0] cfg_addr_i;
  logic [CFG_W-1:0]      cfg_wdata_i;
  logic                  start;
  req_t                  req_i;
  logic                  busy;
  logic                  done_o;
  rsp_t                  rsp_o;

  fixed_block_free_list_allocator dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_addr_i  (cfg_addr_i),
    .cfg_wdata_i (cfg_wdata_i),
    .start       (start),
    .req_i       (req_i),
    .busy        (busy),
    .done_o      (done_o),
    .rsp_o       (rsp_o)
  );

  // shadow copy of the pool: link memory, head, counts and registers
  logic [IDX_W-1:0]  link_mem [MAX_BLOCKS];
  logic [IDX_W-1:0]  pool_head;
  logic [CNT_W-1:0]  pool_free;
  logic [CNT_W-1:0]  pool_total;
  logic [BASE_W-1:0] cfg_base;
  logic [SIZE_W-1:0] cfg_size;
  logic [COUNT_W-1:0] cfg_count;

  // results still owed by the block, oldest first
  rsp_t             pending_rsp [$];
  // blocks handed out and not yet returned, to build well-formed free beats
  logic [IDX_W-1:0] held_blocks [$];
  int unsigned      mismatch_cnt;

  // one row of the directed table: either a register write or a command
  typedef struct {
    bit                is_cfg;
    reg_idx_e          reg_sel;
    logic [CFG_W-1:0]  value;
    logic [1:0]        cmd;
    logic [IDX_W-1:0]  idx;
    bit                known;
    rsp_t              exp;
  } row_t;

  row_t dir_rows [$];

  // clock, 4 ns period
  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // hard stop in case the block hangs
  initial begin
    #20_000_000;
    $display("** fixed_block_free_list_allocator: FAILED **");
    $finish;
  end

  // apply one command to the shadow pool and return the result it yields
  function automatic rsp_t pool_step(req_t r);
    rsp_t        o;
    int unsigned n;
    o = '0;
    o.status = ST_OK;
    case (r.cmd)
      CMD_INIT: begin
        if (cfg_count == '0) begin
          o.status = ST_ZERO_INIT;
        end else begin
          // counts above the pool size are clipped
          n = (cfg_count > MAX_BLOCKS) ? MAX_BLOCKS : cfg_count;
          for (int i = 0; i < n; i++) begin
            // last block links back to block 0, never followed
            link_mem[i] = (i + 1 < n) ? IDX_W'(i + 1) : '0;
          end
          pool_head  = '0;
          pool_free  = CNT_W'(n);
          pool_total = CNT_W'(n);
        end
      end
      CMD_ALLOC: begin
        if (pool_free == '0) begin
          o.status = ST_EMPTY;
        end else begin
          o.alloc_index   = pool_head;
          o.alloc_address = cfg_base + BASE_W'(pool_head) * BASE_W'(cfg_size);
          pool_head = link_mem[pool_head];
          pool_free = pool_free - CNT_W'(1);
        end
      end
      CMD_FREE: begin
        if (CNT_W'(r.block_index) >= pool_total) begin
          o.status = ST_BAD_INDEX;
        end else if (pool_free < pool_total) begin
          // push only while not full, a full list stays intact
          link_mem[r.block_index] = pool_head;
          pool_head = r.block_index;
          pool_free = pool_free + CNT_W'(1);
        end
      end
      default: ;
    endcase
    o.free_blocks = pool_free;
    return o;
  endfunction

  function automatic rsp_t mk_rsp(status_e st, logic [IDX_W-1:0] ai,
                                  logic [BASE_W-1:0] aa, logic [CNT_W-1:0] fb);
    rsp_t o;
    o.status        = st;
    o.alloc_index   = ai;
    o.alloc_address = aa;
    o.free_blocks   = fb;
    return o;
  endfunction

  function automatic void add_cfg(reg_idx_e r, logic [CFG_W-1:0] v);
    row_t w;
    w.is_cfg  = 1'b1;
    w.reg_sel = r;
    w.value   = v;
    w.cmd     = '0;
    w.idx     = '0;
    w.known   = 1'b0;
    w.exp     = '0;
    dir_rows.push_back(w);
  endfunction

  function automatic void add_cmd(logic [1:0] c, logic [IDX_W-1:0] idx,
                                  bit known, rsp_t e);
    row_t w;
    w.is_cfg  = 1'b0;
    w.reg_sel = REG_BASE;
    w.value   = '0;
    w.cmd     = c;
    w.idx     = idx;
    w.known   = known;
    w.exp     = e;
    dir_rows.push_back(w);
  endfunction

  // drive one command beat and hold it until the block takes it
  task automatic send_cmd(logic [1:0] c, logic [IDX_W-1:0] idx, bit known, rsp_t e);
    req_t r;
    rsp_t p;
    r.cmd         = c;
    r.block_index = idx;
    start <= 1'b1;
    req_i <= r;
    do @(posedge clk_i); while (busy);
    p = pool_step(r);
    pending_rsp.push_back(known ? e : p);
    if (c == CMD_INIT && p.status == ST_OK) held_blocks.delete();
    if (c == CMD_ALLOC && p.status == ST_OK) held_blocks.push_back(p.alloc_index);
  endtask

  task automatic idle_gap(int unsigned n);
    start <= 1'b0;
    repeat (n) @(posedge clk_i);
  endtask

  // stop sending and wait until every owed result has come back
  task automatic settle();
    start <= 1'b0;
    while (pending_rsp.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // register write, only issued while the block is idle
  task automatic cfg_write(reg_idx_e r, logic [CFG_W-1:0] v);
    cfg_we_i    <= 1'b1;
    cfg_addr_i  <= r;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
    case (r)
      REG_BASE:  cfg_base  = v[BASE_W-1:0];
      REG_SIZE:  cfg_size  = v[SIZE_W-1:0];
      REG_COUNT: cfg_count = v[COUNT_W-1:0];
      default: ;
    endcase
  endtask

  // random gap after a beat, roughly 38 percent of the time
  task automatic maybe_idle(bit idle_on);
    if (idle_on && $urandom_range(99) < 38) idle_gap($urandom_range(1, 4));
  endtask

  // result checker: each done beat against the oldest owed result
  always @(posedge clk_i) begin
    rsp_t e;
    if (rst_ni && done_o) begin
      if (pending_rsp.size() == 0) begin
        mismatch_cnt++;
        if (mismatch_cnt <= MAX_ERR_LOG)
          $display("[%0t] unexpected result beat: status %0d idx %0d addr %h free %0d",
                   $realtime, rsp_o.status, rsp_o.alloc_index, rsp_o.alloc_address,
                   rsp_o.free_blocks);
      end else begin
        e = pending_rsp.pop_front();
        if (rsp_o.status !== e.status || rsp_o.alloc_index !== e.alloc_index ||
            rsp_o.alloc_address !== e.alloc_address ||
            rsp_o.free_blocks !== e.free_blocks) begin
          mismatch_cnt++;
          if (mismatch_cnt <= MAX_ERR_LOG)
            $display("[%0t] mismatch: exp status %0d idx %0d addr %h free %0d, got %0d %0d %h %0d",
                     $realtime, e.status, e.alloc_index, e.alloc_address, e.free_blocks,
                     rsp_o.status, rsp_o.alloc_index, rsp_o.alloc_address,
                     rsp_o.free_blocks);
        end
      end
    end
  end

  // stimulus
  initial begin
    int unsigned      sel;
    int unsigned      k;
    bit               idle_on;
    logic [IDX_W-1:0] idx;
    logic [CFG_W-1:0] base_v;
    logic [CFG_W-1:0] size_v;
    logic [CFG_W-1:0] count_v;

    // every input known from time zero, reset held asserted before release
    rst_ni      = 1'b0;
    cfg_we_i    = 1'b0;
    cfg_addr_i  = REG_BASE;
    cfg_wdata_i = '0;
    start       = 1'b0;
    req_i       = '0;
    mismatch_cnt = 0;

    // shadow state after reset
    cfg_base   = BASE_RST;
    cfg_size   = SIZE_RST;
    cfg_count  = COUNT_RST;
    pool_head  = '0;
    pool_free  = '0;
    pool_total = '0;
    for (int i = 0; i < MAX_BLOCKS; i++) link_mem[i] = '0;

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // directed table, typed results only where they are obvious
    // before any init: alloc finds nothing, every free index is out of range
    add_cmd(CMD_ALLOC, 8'd0, 1'b1, mk_rsp(ST_EMPTY, 8'd0, 32'd0, 9'd0));
    add_cmd(CMD_FREE, 8'd0, 1'b1, mk_rsp(ST_BAD_INDEX, 8'd0, 32'd0, 9'd0));
    add_cmd(CMD_FREE, 8'd255, 1'b1, mk_rsp(ST_BAD_INDEX, 8'd0, 32'd0, 9'd0));
    add_cmd(CMD_UNUSED, 8'hAA, 1'b1, mk_rsp(ST_OK, 8'd0, 32'd0, 9'd0));
    // zero count init is refused
    add_cfg(REG_COUNT, 32'd0);
    add_cmd(CMD_INIT, 8'd0, 1'b1, mk_rsp(ST_ZERO_INIT, 8'd0, 32'd0, 9'd0));
    // oversized count clipped to the pool, address wraps past 2^32
    add_cfg(REG_BASE, 32'hFFFF_FFC0);
    add_cfg(REG_SIZE, 32'd65535);
    add_cfg(REG_COUNT, 32'd511);
    add_cmd(CMD_INIT, 8'd0, 1'b1, mk_rsp(ST_OK, 8'd0, 32'd0, 9'd256));
    add_cmd(CMD_ALLOC, 8'd0, 1'b1, mk_rsp(ST_OK, 8'd0, 32'hFFFF_FFC0, 9'd255));
    add_cmd(CMD_ALLOC, 8'd0, 1'b1, mk_rsp(ST_OK, 8'd1, 32'h0000_FFBF, 9'd254));
    add_cmd(CMD_FREE, 8'd255, 1'b1, mk_rsp(ST_OK, 8'd0, 32'd0, 9'd255));
    add_cmd(CMD_ALLOC, 8'd0, 1'b0, '0);
    add_cmd(CMD_FREE, 8'd0, 1'b0, '0);
    add_cmd(CMD_FREE, 8'd1, 1'b1, mk_rsp(ST_OK, 8'd0, 32'd0, 9'd256));
    // free on a full pool saturates and drops the push
    add_cmd(CMD_FREE, 8'd7, 1'b1, mk_rsp(ST_OK, 8'd0, 32'd0, 9'd256));
    add_cmd(CMD_ALLOC, 8'd0, 1'b0, '0);
    // single block pool: empty, bad index and saturation all one step apart
    add_cfg(REG_BASE, 32'd0);
    add_cfg(REG_SIZE, 32'd1);
    add_cfg(REG_COUNT, 32'd1);
    add_cmd(CMD_INIT, 8'd0, 1'b1, mk_rsp(ST_OK, 8'd0, 32'd0, 9'd1));
    add_cmd(CMD_ALLOC, 8'd0, 1'b1, mk_rsp(ST_OK, 8'd0, 32'd0, 9'd0));
    add_cmd(CMD_ALLOC, 8'd0, 1'b1, mk_rsp(ST_EMPTY, 8'd0, 32'd0, 9'd0));
    add_cmd(CMD_FREE, 8'd1, 1'b1, mk_rsp(ST_BAD_INDEX, 8'd0, 32'd0, 9'd0));
    add_cmd(CMD_FREE, 8'd0, 1'b1, mk_rsp(ST_OK, 8'd0, 32'd0, 9'd1));
    add_cmd(CMD_FREE, 8'd0, 1'b1, mk_rsp(ST_OK, 8'd0, 32'd0, 9'd1));
    // all-ones base, exact pool size
    add_cfg(REG_BASE, 32'hFFFF_FFFF);
    add_cfg(REG_SIZE, 32'd64);
    add_cfg(REG_COUNT, 32'd256);
    add_cmd(CMD_INIT, 8'd0, 1'b1, mk_rsp(ST_OK, 8'd0, 32'd0, 9'd256));
    add_cmd(CMD_ALLOC, 8'd0, 1'b1, mk_rsp(ST_OK, 8'd0, 32'hFFFF_FFFF, 9'd255));
    add_cmd(CMD_UNUSED, 8'h55, 1'b1, mk_rsp(ST_OK, 8'd0, 32'd0, 9'd255));
    add_cmd(CMD_FREE, 8'hFF, 1'b0, '0);

    foreach (dir_rows[i]) begin
      if (dir_rows[i].is_cfg) begin
        settle();
        cfg_write(dir_rows[i].reg_sel, dir_rows[i].value);
      end else begin
        send_cmd(dir_rows[i].cmd, dir_rows[i].idx, dir_rows[i].known, dir_rows[i].exp);
        maybe_idle(1'b1);
      end
    end

    // random phases, each with its own register setting and a fresh init
    for (int ph = 0; ph < PHASES; ph++) begin
      // pause until the block has answered everything, then reprogram
      settle();
      case (ph % 3)
        0:       base_v = 32'd0;
        1:       base_v = 32'hFFFF_FFFF;
        default: base_v = $urandom;
      endcase
      case (ph)
        1:       size_v = 32'd1;
        2:       size_v = 32'd65535;
        default: size_v = $urandom_range(1, 65535);
      endcase
      // mostly small pools so empty and full are hit often
      case (ph)
        0:       count_v = 32'd4;
        1:       count_v = 32'd256;
        2:       count_v = 32'd1;
        3:       count_v = 32'd16;
        4:       count_v = 32'd2;
        5:       count_v = $urandom_range(100, 255);
        6:       count_v = $urandom_range(3, 12);
        default: count_v = 32'd256;
      endcase
      cfg_write(REG_BASE, base_v);
      cfg_write(REG_SIZE, size_v);
      cfg_write(REG_COUNT, count_v);

      // one phase runs back to back with no gaps at all
      idle_on = (ph != 3);
      send_cmd(CMD_INIT, IDX_W'($urandom), 1'b0, '0);

      for (int n = 0; n < PHASE_ITEMS; n++) begin
        sel = $urandom_range(99);
        if (sel < 45) begin
          send_cmd(CMD_ALLOC, IDX_W'($urandom), 1'b0, '0);
        end else if (sel < 82) begin
          // return a block that is actually out, the normal case
          if (held_blocks.size() != 0) begin
            k   = $urandom_range(held_blocks.size() - 1);
            idx = held_blocks[k];
            held_blocks.delete(k);
          end else begin
            idx = (pool_total != 0) ? IDX_W'($urandom_range(pool_total - 1)) : '0;
          end
          send_cmd(CMD_FREE, idx, 1'b0, '0);
        end else if (sel < 90) begin
          // any index, including double frees and out of range
          send_cmd(CMD_FREE, IDX_W'($urandom), 1'b0, '0);
        end else if (sel < 94) begin
          send_cmd(CMD_INIT, IDX_W'($urandom), 1'b0, '0);
        end else if (sel < 97) begin
          send_cmd(CMD_UNUSED, IDX_W'($urandom), 1'b0, '0);
        end else begin
          // indices right at the range edge
          idx = IDX_W'(pool_total - ($urandom_range(1) == 0 ? 1 : 0));
          send_cmd(CMD_FREE, idx, 1'b0, '0);
        end
        maybe_idle(idle_on);
      end
    end

    // drain, then keep watching for stray beats before the verdict
    settle();
    repeat (20) @(posedge clk_i);
    if (mismatch_cnt == 0 && pending_rsp.size() == 0) begin
      $display("** fixed_block_free_list_allocator: PASSED **");
    end else begin
      $display("** fixed_block_free_list_allocator: FAILED **");
    end
    $finish;
  end

endmodule
